FILE: rtl/gbn_pkg.sv
// Shared types and constants for the go-back-N sender window.
// Used by gbn_step and the top level; depends on nothing else.
package gbn_pkg;

    localparam int SEQ_W = 32;
    localparam int TAG_W = 16;
    localparam int LEN_W = 11;
    localparam int LIMIT_W = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd4;
    localparam logic [SEQ_W-1:0]   SEQ_RESET   = 32'd1;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_RECV    = 2'd1,
        OP_TIMEOUT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_OOW     = 2'd1,
        STAT_QUEUED  = 2'd2,
        STAT_DROPPED = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_RD,
        S_EMIT,
        S_SLIDE,
        S_DCHK,
        S_DEMIT
    } st_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
    } frame_t;

endpackage

FILE: rtl/gbn_step.sv
// Shared sequence stepper: advances a sequence number and its slot index.
// Depends on gbn_pkg for the sequence width.
module gbn_step
    import gbn_pkg::*;
#(
    parameter int SLOTS = 8,
    parameter int IDX_W = 3
)
(
    input  logic [SEQ_W-1:0] seq_in,
    input  logic [IDX_W-1:0] idx_in,
    output logic [SEQ_W-1:0] seq_out,
    output logic [IDX_W-1:0] idx_out
);

    assign seq_out = seq_in + SEQ_W'(1);

    // The slot index is the sequence modulo SLOTS, so it restarts at zero
    // both at the slot boundary and when the sequence itself wraps.
    always_comb
    begin
        if (seq_in == {SEQ_W{1'b1}} || idx_in == IDX_W'(SLOTS - 1))
        begin
            idx_out = '0;
        end
        else
        begin
            idx_out = idx_in + IDX_W'(1);
        end
    end

endmodule

FILE: rtl/gbn_ram.sv
// Simple dual-port memory with one write port and one registered read port.
// Stand-alone; holds frame slots and the wait queue.
module gbn_ram
#(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 27,
    parameter int ADDR_W = 3
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/go_back_n_arq_sender.sv
// Top level of the go-back-N sender window: event sequencer and state.
// Depends on gbn_pkg, gbn_step and gbn_ram.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  event   | in        | in_valid / in_stall  | opcode frame_tag frame_len is_nak ack_number
//  result  | out       | out_valid / out_stall| send_valid send_tag send_len status last
//  config  | in        | cfg_write            | cfg_data (window limit)
//
// A send, an unknown opcode or an out-of-window ack gives a single result.
// Timeout and NAK resend each frame by a slot memory read, then output.
// An ACK slides the base one past the ack, then drains each queued frame that
// fits the window (wait queue read, then output), or gives one empty result.
// Reset is asynchronous and needs no clearing pass; the memories hold no state
// until written. A stalled result holds the sequencer until it is taken.
module go_back_n_arq_sender
    import gbn_pkg::*;
#(
    parameter int WINDOW_SLOTS = 8,
    parameter int WAIT_DEPTH   = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [TAG_W-1:0]   frame_tag,
    input  logic [LEN_W-1:0]   frame_len,
    input  logic               is_nak,
    input  logic [SEQ_W-1:0]   ack_number,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               send_valid,
    output logic [TAG_W-1:0]   send_tag,
    output logic [LEN_W-1:0]   send_len,
    output logic [1:0]         status,
    output logic               last
);

    localparam int IDX_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);
    localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int PTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);
    localparam int FR_W   = $bits(frame_t);
    localparam logic [IDX_W-1:0] IDX_RESET = IDX_W'(1 % WINDOW_SLOTS);

    st_t state_reg, state_next;

    logic [1:0]         op_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               nak_reg;
    logic [SEQ_W-1:0]   ack_reg;

    logic [LIMIT_W-1:0] limit_reg;
    logic [SEQ_W-1:0]   base_reg, base_next;
    logic [IDX_W-1:0]   base_idx_reg, base_idx_next;
    logic [SEQ_W-1:0]   next_seq_reg, next_seq_next;
    logic [IDX_W-1:0]   next_idx_reg, next_idx_next;
    logic [CNT_W-1:0]   out_cnt_reg, out_cnt_next;
    logic [SEQ_W-1:0]   cur_seq_reg, cur_seq_next;
    logic [IDX_W-1:0]   cur_idx_reg, cur_idx_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [WCNT_W-1:0]  wcount_reg, wcount_next;

    logic               out_valid_reg, out_valid_next;
    logic               send_valid_reg;
    logic [TAG_W-1:0]   send_tag_reg;
    logic [LEN_W-1:0]   send_len_reg;
    logic [1:0]         status_reg;
    logic               last_reg;

    logic               ld;
    logic               ld_valid;
    frame_t             ld_frame;
    stat_t              ld_status;
    logic               ld_last;

    logic               in_accept;
    logic               out_free;
    logic [CMP_W-1:0]   lim;
    logic [CMP_W-1:0]   cnt_cmp;
    logic [SEQ_W-1:0]   off_full;
    logic               off_oow;
    logic [CNT_W-1:0]   off_small;
    logic               can_drain;
    logic               more_drain;

    logic [SEQ_W-1:0]   step_seq_in, step_seq_out;
    logic [IDX_W-1:0]   step_idx_in, step_idx_out;

    logic               slot_we, slot_re;
    logic [IDX_W-1:0]   slot_waddr;
    frame_t             slot_wdata;
    frame_t             slot_rdata;
    logic               fifo_we, fifo_re;
    frame_t             fifo_rdata;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // Effective window limit: zero acts as one, and it never exceeds the slot count.
    always_comb
    begin
        lim = CMP_W'(limit_reg);
        if (lim == '0)
        begin
            lim = CMP_W'(1);
        end
        else if (lim > CMP_W'(WINDOW_SLOTS))
        begin
            lim = CMP_W'(WINDOW_SLOTS);
        end
    end

    assign cnt_cmp    = CMP_W'(out_cnt_reg);
    assign off_full   = ack_reg - base_reg;
    assign off_oow    = off_full >= SEQ_W'(out_cnt_reg);
    assign off_small  = off_full[CNT_W-1:0];
    assign can_drain  = (wcount_reg != '0) && (cnt_cmp < lim);
    assign more_drain = (wcount_reg > WCNT_W'(1)) && ((cnt_cmp + CMP_W'(1)) < lim);

    // One stepper serves the resend cursor, the sliding base and the send pointer.
    always_comb
    begin
        unique case (state_reg)
            S_EMIT:
            begin
                step_seq_in = cur_seq_reg;
                step_idx_in = cur_idx_reg;
            end
            S_SLIDE:
            begin
                step_seq_in = base_reg;
                step_idx_in = base_idx_reg;
            end
            default:
            begin
                step_seq_in = next_seq_reg;
                step_idx_in = next_idx_reg;
            end
        endcase
    end

    gbn_step #(
        .SLOTS (WINDOW_SLOTS),
        .IDX_W (IDX_W)
    ) u_step (
        .seq_in  (step_seq_in),
        .idx_in  (step_idx_in),
        .seq_out (step_seq_out),
        .idx_out (step_idx_out)
    );

    gbn_ram #(
        .DEPTH  (WINDOW_SLOTS),
        .WIDTH  (FR_W),
        .ADDR_W (IDX_W)
    ) u_slots (
        .clk     (clk),
        .wr_en   (slot_we),
        .wr_addr (slot_waddr),
        .wr_data (slot_wdata),
        .rd_en   (slot_re),
        .rd_addr (cur_idx_reg),
        .rd_data (slot_rdata)
    );

    gbn_ram #(
        .DEPTH  (WAIT_DEPTH),
        .WIDTH  (FR_W),
        .ADDR_W (PTR_W)
    ) u_wait (
        .clk     (clk),
        .wr_en   (fifo_we),
        .wr_addr (tail_reg),
        .wr_data ({tag_reg, len_reg}),
        .rd_en   (fifo_re),
        .rd_addr (head_reg),
        .rd_data (fifo_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        base_next     = base_reg;
        base_idx_next = base_idx_reg;
        next_seq_next = next_seq_reg;
        next_idx_next = next_idx_reg;
        out_cnt_next  = out_cnt_reg;
        cur_seq_next  = cur_seq_reg;
        cur_idx_next  = cur_idx_reg;
        remain_next   = remain_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        wcount_next   = wcount_reg;
        slot_we       = 1'b0;
        slot_re       = 1'b0;
        slot_waddr    = next_idx_reg;
        slot_wdata    = {tag_reg, len_reg};
        fifo_we       = 1'b0;
        fifo_re       = 1'b0;
        ld            = 1'b0;
        ld_valid      = 1'b0;
        ld_frame      = '0;
        ld_status     = STAT_OK;
        ld_last       = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    unique case (op_reg)
                        OP_SEND:
                        begin
                            ld = 1'b1;
                            if (cnt_cmp < lim)
                            begin
                                slot_we       = 1'b1;
                                next_seq_next = step_seq_out;
                                next_idx_next = step_idx_out;
                                out_cnt_next  = out_cnt_reg + CNT_W'(1);
                                ld_valid      = 1'b1;
                                ld_frame      = {tag_reg, len_reg};
                            end
                            else if (wcount_reg < WCNT_W'(WAIT_DEPTH))
                            begin
                                fifo_we     = 1'b1;
                                tail_next   = (tail_reg == PTR_W'(WAIT_DEPTH - 1)) ?
                                              '0 : tail_reg + PTR_W'(1);
                                wcount_next = wcount_reg + WCNT_W'(1);
                                ld_status   = STAT_QUEUED;
                            end
                            else
                            begin
                                ld_status = STAT_DROPPED;
                            end
                        end
                        OP_TIMEOUT:
                        begin
                            if (out_cnt_reg == '0)
                            begin
                                ld = 1'b1;
                            end
                            else
                            begin
                                cur_seq_next = base_reg;
                                cur_idx_next = base_idx_reg;
                                remain_next  = out_cnt_reg;
                                state_next   = S_RD;
                            end
                        end
                        OP_RECV:
                        begin
                            if (off_oow)
                            begin
                                ld        = 1'b1;
                                ld_status = STAT_OOW;
                            end
                            else if (nak_reg)
                            begin
                                if (off_small == '0)
                                begin
                                    ld = 1'b1;
                                end
                                else
                                begin
                                    cur_seq_next = base_reg;
                                    cur_idx_next = base_idx_reg;
                                    remain_next  = off_small;
                                    state_next   = S_RD;
                                end
                            end
                            else
                            begin
                                // The base moves one past the ack, one sequence per cycle.
                                remain_next = off_small + CNT_W'(1);
                                state_next  = S_SLIDE;
                            end
                        end
                        default:
                        begin
                            ld = 1'b1;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                slot_re    = 1'b1;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    ld           = 1'b1;
                    ld_valid     = 1'b1;
                    ld_frame     = slot_rdata;
                    ld_last      = (remain_reg == CNT_W'(1));
                    cur_seq_next = step_seq_out;
                    cur_idx_next = step_idx_out;
                    remain_next  = remain_reg - CNT_W'(1);
                    state_next   = (remain_reg == CNT_W'(1)) ? S_IDLE : S_RD;
                end
            end

            S_SLIDE:
            begin
                base_next     = step_seq_out;
                base_idx_next = step_idx_out;
                out_cnt_next  = out_cnt_reg - CNT_W'(1);
                remain_next   = remain_reg - CNT_W'(1);
                if (remain_reg == CNT_W'(1))
                begin
                    state_next = S_DCHK;
                end
            end

            S_DCHK:
            begin
                if (can_drain)
                begin
                    fifo_re    = 1'b1;
                    state_next = S_DEMIT;
                end
                else if (out_free)
                begin
                    // Nothing to drain after the slide gives one empty transfer.
                    ld         = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DEMIT:
            begin
                if (out_free)
                begin
                    slot_we       = 1'b1;
                    slot_wdata    = fifo_rdata;
                    next_seq_next = step_seq_out;
                    next_idx_next = step_idx_out;
                    out_cnt_next  = out_cnt_reg + CNT_W'(1);
                    head_next     = (head_reg == PTR_W'(WAIT_DEPTH - 1)) ?
                                    '0 : head_reg + PTR_W'(1);
                    wcount_next   = wcount_reg - WCNT_W'(1);
                    ld            = 1'b1;
                    ld_valid      = 1'b1;
                    ld_frame      = fifo_rdata;
                    ld_last       = !more_drain;
                    state_next    = more_drain ? S_DCHK : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ld)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_RESET;
            base_reg      <= SEQ_RESET;
            base_idx_reg  <= IDX_RESET;
            next_seq_reg  <= SEQ_RESET;
            next_idx_reg  <= IDX_RESET;
            out_cnt_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            wcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_write)
            begin
                limit_reg <= cfg_data;
            end
            base_reg      <= base_next;
            base_idx_reg  <= base_idx_next;
            next_seq_reg  <= next_seq_next;
            next_idx_reg  <= next_idx_next;
            out_cnt_reg   <= out_cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            wcount_reg    <= wcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg  <= opcode;
            tag_reg <= frame_tag;
            len_reg <= frame_len;
            nak_reg <= is_nak;
            ack_reg <= ack_number;
        end
        cur_seq_reg <= cur_seq_next;
        cur_idx_reg <= cur_idx_next;
        remain_reg  <= remain_next;
        if (ld)
        begin
            send_valid_reg <= ld_valid;
            send_tag_reg   <= ld_frame.tag;
            send_len_reg   <= ld_frame.len;
            status_reg     <= ld_status;
            last_reg       <= ld_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign send_valid = send_valid_reg;
    assign send_tag   = send_tag_reg;
    assign send_len   = send_len_reg;
    assign status     = status_reg;
    assign last       = last_reg;

`ifndef SYNTH
    a_seq_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        next_seq_reg == base_reg + SEQ_W'(out_cnt_reg))
        else $error("next sequence does not match base plus outstanding count");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg <= CNT_W'(WINDOW_SLOTS))
        else $error("outstanding count exceeds slot count");

    a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wcount_reg <= WCNT_W'(WAIT_DEPTH))
        else $error("wait queue count exceeds depth");

    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |-> (state_reg != S_IDLE))
        else $error("event finished before its final transfer");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (base_idx_reg <= IDX_W'(WINDOW_SLOTS - 1)) &&
        (next_idx_reg <= IDX_W'(WINDOW_SLOTS - 1)))
        else $error("slot index out of range");
`endif

endmodule
